// ===== src/sdaf_pkg.sv =====
// ============================================================================
// sdaf_pkg
// Shared types and constants for the signed decimal ASCII formatter.
// ============================================================================
package sdaf_pkg;

    // ASCII codes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // floor(m / 10) == (m * RECIP_DIV10) >> RECIP_SHIFT for every 32-bit m
    localparam logic [31:0] RECIP_DIV10 = 32'hCCCC_CCCD;
    localparam int unsigned RECIP_SHIFT = 35;

    localparam int unsigned VALUE_W = 32;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_ZERO,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // take in a new value
        logic multiply;    // form magnitude times reciprocal
        logic step;        // store digit, replace magnitude by quotient
        logic emit_zero;   // load '0' with last
        logic emit_sign;   // load '-'
        logic emit_digit;  // load next stored digit
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic mag_zero;    // magnitude fully divided down
        logic count_zero;  // no digits held
        logic count_one;   // one digit left to send
        logic count_full;  // digit store full
        logic negative;    // current value is negative
        logic out_free;    // output register can take a beat this cycle
    } status_t;

endpackage : sdaf_pkg

// ===== src/sdaf_ctrl.sv =====
// ============================================================================
// sdaf_ctrl
// Controller: sequences load, digit extraction and character output.
// ============================================================================
module sdaf_ctrl
    import sdaf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.mag_zero || status.count_full)
                begin
                    if (status.count_zero)
                    begin
                        state_next = ST_ZERO;
                    end
                    else if (status.negative)
                    begin
                        state_next = ST_SIGN;
                    end
                    else
                    begin
                        state_next = ST_DIGITS;
                    end
                end
                else
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                state_next = ST_CHECK;
            end
            ST_ZERO:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SIGN:
            begin
                if (status.out_free)
                begin
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (status.out_free && status.count_one)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_CHECK:
            begin
                cmd.multiply = !(status.mag_zero || status.count_full);
            end
            ST_DIVIDE:
            begin
                cmd.step = 1'b1;
            end
            ST_ZERO:
            begin
                cmd.emit_zero = status.out_free;
            end
            ST_SIGN:
            begin
                cmd.emit_sign = status.out_free;
            end
            ST_DIGITS:
            begin
                cmd.emit_digit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule : sdaf_ctrl

// ===== src/sdaf_datapath.sv =====
// ============================================================================
// sdaf_datapath
// Magnitude, reciprocal divide-by-ten, digit store and output register.
// ============================================================================
module sdaf_datapath
    import sdaf_pkg::*;
#(
    parameter int MAX_DIGITS = 10
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic signed [31:0]  value,
    input  cmd_t                cmd,
    output status_t             status,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          character,
    output logic                last
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = $clog2(MAX_DIGITS);

    logic [VALUE_W-1:0]   mag_reg;
    logic [VALUE_W-1:0]   mag_next;
    logic                 neg_reg;
    logic [2*VALUE_W-1:0] prod_reg;
    logic [2*VALUE_W-1:0] prod_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_dec;
    logic [3:0]           store_reg [MAX_DIGITS];
    logic [VALUE_W-1:0]   quot;
    logic [VALUE_W-1:0]   quot_x10;
    logic [VALUE_W-1:0]   rem_full;
    logic [3:0]           rd_digit;
    logic                 out_valid_reg;
    logic [7:0]           char_reg;
    logic                 last_reg;
    logic                 out_load;

    // Magnitude of the incoming value; the most negative value wraps to 2^31
    assign mag_next  = value[31] ? (VALUE_W'(0) - $unsigned(value)) : $unsigned(value);

    // Quotient and remainder from the registered product
    assign prod_next = mag_reg * RECIP_DIV10;
    assign quot      = VALUE_W'(prod_reg[2*VALUE_W-1:RECIP_SHIFT]);
    assign quot_x10  = (quot << 3) + (quot << 1);
    assign rem_full  = mag_reg - quot_x10;
    assign count_dec = count_reg - CNT_W'(1);
    assign rd_digit  = store_reg[count_dec[IDX_W-1:0]];

    // Magnitude, sign and digit count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg   <= '0;
            neg_reg   <= 1'b0;
            count_reg <= '0;
        end
        else if (cmd.load)
        begin
            mag_reg   <= mag_next;
            neg_reg   <= value[31];
            count_reg <= '0;
        end
        else if (cmd.step)
        begin
            mag_reg   <= quot;
            count_reg <= count_reg + CNT_W'(1);
        end
        else if (cmd.emit_digit)
        begin
            count_reg <= count_dec;
        end
    end

    // Product register between multiply and remainder
    always_ff @(posedge clk)
    begin
        if (cmd.multiply)
        begin
            prod_reg <= prod_next;
        end
    end

    // Digit store, least significant digit at entry zero
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            store_reg[count_reg[IDX_W-1:0]] <= rem_full[3:0];
        end
    end

    // Output register: hold while stalled, drop once taken
    assign out_load = cmd.emit_zero || cmd.emit_sign || cmd.emit_digit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_zero)
        begin
            char_reg <= CHAR_ZERO;
            last_reg <= 1'b1;
        end
        else if (cmd.emit_sign)
        begin
            char_reg <= CHAR_MINUS;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            char_reg <= CHAR_ZERO + {4'b0, rd_digit};
            last_reg <= (count_reg == CNT_W'(1));
        end
    end

    // Status to controller
    always_comb
    begin
        status.mag_zero   = (mag_reg == '0);
        status.count_zero = (count_reg == '0);
        status.count_one  = (count_reg == CNT_W'(1));
        status.count_full = (count_reg == CNT_W'(MAX_DIGITS));
        status.negative   = neg_reg;
        status.out_free   = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

endmodule : sdaf_datapath

// ===== src/signed_decimal_ascii_formatter_core.sv =====
// ============================================================================
// signed_decimal_ascii_formatter_core
// Formats a signed 32-bit integer as decimal ASCII text, one character per
// beat, most significant digit first, with last on the final character.
// ============================================================================
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------
//   in      | input     | in_valid / in_stall  | value[31:0] signed
//   out     | output    | out_valid / out_stall| character[7:0], last
//
// For each digit, ST_CHECK registers the 32x32 multiply by the reciprocal of
// ten and ST_DIVIDE forms the remainder and stores it. Once all digits are
// held, the characters follow, paused while out is stalled; a run holds up to
// eleven characters. A new value is taken only back in ST_IDLE.
// Reset clears the controller, magnitude, sign, digit count and output valid;
// the digit store is written before use.
// A stall on out holds the output register and pauses the character phase.
// ============================================================================
module signed_decimal_ascii_formatter_core
    import sdaf_pkg::*;
#(
    parameter int MAX_DIGITS = 10
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         character,
    output logic               last
);

    cmd_t    cmd;
    status_t status;

    // Controller
    sdaf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath
    sdaf_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last      (last)
    );

endmodule : signed_decimal_ascii_formatter_core
